// File: src/chr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

    localparam int unsigned FIELD_W = 32;

    // link states
    localparam logic [2:0] ST_CLOSED      = 3'd0;
    localparam logic [2:0] ST_SYN_SENT    = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_FIN_WAIT    = 3'd3;
    localparam logic [2:0] ST_TIME_WAIT   = 3'd4;

    // reported events
    localparam logic [2:0] EV_NONE          = 3'd0;
    localparam logic [2:0] EV_CONNECTED     = 3'd1;
    localparam logic [2:0] EV_OPEN_FAILED   = 3'd2;
    localparam logic [2:0] EV_CLOSE_FAILED  = 3'd3;
    localparam logic [2:0] EV_CLOSED        = 3'd4;
    localparam logic [2:0] EV_RETRANSMITTED = 3'd5;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_OPEN   = 2'd2;
    localparam logic [1:0] KIND_CLOSE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WAIT_TICKS   = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_LINGER_TICKS = 2'd2;

    localparam logic [15:0] WAIT_TICKS_RST   = 16'd200;
    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd10;
    localparam logic [15:0] LINGER_TICKS_RST = 16'd400;

    typedef struct packed {
        logic [1:0]         kind;
        logic               rx_syn;
        logic               rx_ack;
        logic               rx_fin;
        logic [FIELD_W-1:0] rx_seq;
        logic [FIELD_W-1:0] rx_ack_number;
        logic               rx_checksum_ok;
    } in_word_t;

    typedef struct packed {
        logic               send_packet;
        logic               tx_syn;
        logic               tx_ack;
        logic               tx_fin;
        logic [FIELD_W-1:0] tx_seq;
        logic [FIELD_W-1:0] tx_ack_number;
        logic [2:0]         link_state;
        logic [2:0]         event_res;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_word_t;

    typedef struct packed {
        logic [15:0] wait_ticks;
        logic [7:0]  retry_limit;
        logic [15:0] linger_ticks;
    } cfg_regs_t;

    // handshake progress apart from the sequence number
    typedef struct packed {
        logic [2:0]  conn_state;
        logic [7:0]  retry_count;
        logic [15:0] wait_timer;
    } ctrl_t;

endpackage

`default_nettype wire

// File: src/chr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface chr_item_if import chr_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chr_result_if import chr_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chr_cfg_if import chr_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/connection_handshake_with_retry_core.sv
`timescale 1ns / 1ps
`default_nettype none

// client side of a tcp-style open and close handshake with resend on timeout
// item channel: ticks, received packets and open or close commands, one word each
// result channel: exactly one word per item, carrying the control packet to send
//   (if any), the link state after the item and an event code
// cfg channel: register writes (wait ticks, retry limit, linger ticks), always ready,
//   to be written only while no item is in flight; unknown indexes are dropped
// path: a taken item waits in the input register, then its result in the result register,
//   from which it is offered
// throughput: one item per cycle while results are taken; the state update is a single pass
//   of compare and increment logic between the input and result registers
// stall: a held result keeps its register; one more item waits in the input
//   register, after which item.ready drops until the result is taken
// reset: link closed, sequence zero, counters cleared, registers 200 / 10 / 400,
//   both pipeline registers empty
module connection_handshake_with_retry_core import chr_pkg::*; #(
    parameter int unsigned SEQ_WIDTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    chr_item_if.sink      item,
    chr_result_if.source  result,
    chr_cfg_if.sink       cfg
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    in_word_t             in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_word_t            out_data_reg;
    out_word_t            step_res;
    cfg_regs_t            regs_reg;
    ctrl_t                ctrl_reg;
    ctrl_t                ctrl_next;
    logic [SEQ_WIDTH-1:0] send_seq_reg;
    logic [SEQ_WIDTH-1:0] send_seq_next;
    logic                 advance;
    logic                 take_in;

    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;
    assign take_in    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = (in_valid_reg && advance) || (out_valid_reg && !result.ready);

    chr_step #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_step (
        .word          (in_data_reg),
        .regs          (regs_reg),
        .ctrl          (ctrl_reg),
        .send_seq      (send_seq_reg),
        .ctrl_next     (ctrl_next),
        .send_seq_next (send_seq_next),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            send_seq_reg  <= '0;
            regs_reg      <= '{wait_ticks:   WAIT_TICKS_RST,
                               retry_limit:  RETRY_LIMIT_RST,
                               linger_ticks: LINGER_TICKS_RST};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance)
            begin
                ctrl_reg     <= ctrl_next;
                send_seq_reg <= send_seq_next;
            end
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    CFG_WAIT_TICKS:   regs_reg.wait_ticks   <= cfg.data.data;
                    CFG_RETRY_LIMIT:  regs_reg.retry_limit  <= cfg.data.data[7:0];
                    CFG_LINGER_TICKS: regs_reg.linger_ticks <= cfg.data.data;
                    default:          regs_reg              <= regs_reg;
                endcase
            end
        end
    end

    // payload words, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= item.data;
        end
        if (in_valid_reg && advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

`ifndef SYNTHESIS
    // closed and established always leave the retry and timer counters clear
    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.conn_state == ST_CLOSED || ctrl_reg.conn_state == ST_ESTABLISHED)
        |-> (ctrl_reg.retry_count == 8'd0 && ctrl_reg.wait_timer == 16'd0))
        else $error("counters not clear in a settled state");

    a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("pending word lost on its way to the result register");

    a_quiet_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.send_packet)
        |-> (!out_data_reg.tx_syn && !out_data_reg.tx_ack && !out_data_reg.tx_fin
             && out_data_reg.tx_seq == '0 && out_data_reg.tx_ack_number == '0))
        else $error("packet fields set with no packet to send");

    a_connected_acks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_res == EV_CONNECTED)
        |-> (out_data_reg.send_packet && out_data_reg.tx_ack
             && out_data_reg.link_state == ST_ESTABLISHED))
        else $error("connect reported without its ack");

    a_state_holds_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid_reg && advance) |=> $stable(ctrl_reg) && $stable(send_seq_reg))
        else $error("link state moved with no word processed");
`endif

endmodule

`default_nettype wire

// File: src/chr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module chr_step import chr_pkg::*; #(
    parameter int unsigned SEQ_WIDTH = 32
) (
    input  wire in_word_t             word,
    input  wire cfg_regs_t            regs,
    input  wire ctrl_t                ctrl,
    input  wire logic [SEQ_WIDTH-1:0] send_seq,
    output ctrl_t                     ctrl_next,
    output logic [SEQ_WIDTH-1:0]      send_seq_next,
    output out_word_t                 res
);

    logic [15:0]          wait_lim;
    logic [15:0]          linger_lim;
    logic [15:0]          timer_inc;
    logic [SEQ_WIDTH-1:0] seq_prev;
    logic [SEQ_WIDTH-1:0] seq_inc;
    logic [SEQ_WIDTH-1:0] rx_seq_inc;
    logic                 reply_ok;
    logic                 is_syn;

    // a zero limit behaves as one
    assign wait_lim   = (regs.wait_ticks == 16'd0) ? 16'd1 : regs.wait_ticks;
    assign linger_lim = (regs.linger_ticks == 16'd0) ? 16'd1 : regs.linger_ticks;
    assign timer_inc  = (ctrl.wait_timer == 16'hFFFF) ? 16'hFFFF : ctrl.wait_timer + 16'd1;
    assign seq_prev   = send_seq - SEQ_WIDTH'(1);
    assign seq_inc    = send_seq + SEQ_WIDTH'(1);
    assign rx_seq_inc = word.rx_seq[SEQ_WIDTH-1:0] + SEQ_WIDTH'(1);
    assign reply_ok   = word.rx_checksum_ok && word.rx_ack
                        && (word.rx_ack_number[SEQ_WIDTH-1:0] == send_seq);
    assign is_syn     = (ctrl.conn_state == ST_SYN_SENT);

    always_comb
    begin
        ctrl_next     = ctrl;
        send_seq_next = send_seq;
        res           = '0;
        res.event_res = EV_NONE;
        case (word.kind)
            KIND_TICK:
            begin
                if (ctrl.conn_state == ST_SYN_SENT || ctrl.conn_state == ST_FIN_WAIT)
                begin
                    ctrl_next.wait_timer = timer_inc;
                    if (timer_inc >= wait_lim)
                    begin
                        ctrl_next.wait_timer = 16'd0;
                        if (ctrl.retry_count == regs.retry_limit)
                        begin
                            ctrl_next.conn_state  = is_syn ? ST_CLOSED : ST_ESTABLISHED;
                            ctrl_next.retry_count = 8'd0;
                            res.event_res = is_syn ? EV_OPEN_FAILED : EV_CLOSE_FAILED;
                        end
                        else
                        begin
                            ctrl_next.retry_count = ctrl.retry_count + 8'd1;
                            res.send_packet = 1'b1;
                            res.tx_syn      = is_syn;
                            res.tx_fin      = !is_syn;
                            res.tx_seq      = FIELD_W'(seq_prev);
                            res.event_res   = EV_RETRANSMITTED;
                        end
                    end
                end
                else if (ctrl.conn_state == ST_TIME_WAIT)
                begin
                    ctrl_next.wait_timer = timer_inc;
                    if (timer_inc >= linger_lim)
                    begin
                        ctrl_next.conn_state  = ST_CLOSED;
                        ctrl_next.wait_timer  = 16'd0;
                        ctrl_next.retry_count = 8'd0;
                        send_seq_next         = '0;
                        res.event_res         = EV_CLOSED;
                    end
                end
            end
            KIND_PACKET:
            begin
                if (reply_ok && ((is_syn && word.rx_syn)
                    || (ctrl.conn_state == ST_FIN_WAIT && word.rx_fin)))
                begin
                    res.send_packet       = 1'b1;
                    res.tx_ack            = 1'b1;
                    res.tx_seq            = FIELD_W'(send_seq);
                    res.tx_ack_number     = FIELD_W'(rx_seq_inc);
                    ctrl_next.retry_count = 8'd0;
                    ctrl_next.wait_timer  = 16'd0;
                    if (is_syn)
                    begin
                        ctrl_next.conn_state = ST_ESTABLISHED;
                        res.event_res        = EV_CONNECTED;
                    end
                    else
                    begin
                        ctrl_next.conn_state = ST_TIME_WAIT;
                    end
                end
            end
            KIND_OPEN:
            begin
                if (ctrl.conn_state == ST_CLOSED)
                begin
                    res.send_packet       = 1'b1;
                    res.tx_syn            = 1'b1;
                    res.tx_seq            = FIELD_W'(send_seq);
                    send_seq_next         = seq_inc;
                    ctrl_next.conn_state  = ST_SYN_SENT;
                    ctrl_next.retry_count = 8'd0;
                    ctrl_next.wait_timer  = 16'd0;
                end
            end
            KIND_CLOSE:
            begin
                if (ctrl.conn_state == ST_ESTABLISHED)
                begin
                    res.send_packet       = 1'b1;
                    res.tx_fin            = 1'b1;
                    res.tx_seq            = FIELD_W'(send_seq);
                    send_seq_next         = seq_inc;
                    ctrl_next.conn_state  = ST_FIN_WAIT;
                    ctrl_next.retry_count = 8'd0;
                    ctrl_next.wait_timer  = 16'd0;
                end
            end
            default:
            begin
                ctrl_next = ctrl;
            end
        endcase
        res.link_state = ctrl_next.conn_state;
    end

endmodule

`default_nettype wire
